// ----- src/nstp_pkg.sv -----
// shared types, codes and constants for the nested tlv stream parser
package nstp_pkg;

  localparam int MAX_DEPTH = 8;
  localparam int OFF_W     = 16;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int STK_IW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int HDR_BYTES = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MSG_LEN    = 2'd0,
    CFG_COMP_MASK  = 2'd1,
    CFG_COMP_MATCH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    EV_TYPE    = 3'd0,
    EV_START   = 3'd1,
    EV_DATA    = 3'd2,
    EV_IGNORED = 3'd3,
    EV_ERROR   = 3'd4
  } ev_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TRUNC   = 2'd1,
    ERR_OVERRUN = 2'd2,
    ERR_DEEP    = 2'd3
  } err_code_t;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] node_type;
    logic [7:0] node_length;
    logic [3:0] node_depth;
    logic       is_composite;
    logic [7:0] data_out;
    logic [3:0] closed_count;
    logic       root_done;
    logic [1:0] error_code;
  } out_t;

endpackage

// ----- src/nstp_core.sv -----
// parse state, end offset stack and per-byte event logic
module nstp_core
  import nstp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  take,
  input  in_t                   item,
  output out_t                  result
);

  logic [OFF_W-1:0]   msg_len_r;
  logic [7:0]         comp_mask_r;
  logic [7:0]         comp_match_r;

  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [OFF_W-1:0]   leaf_r, leaf_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  phase_t             phase_r, phase_nxt;
  logic [7:0]         held_r, held_nxt;
  status_t            status_r, status_nxt;
  err_code_t          err_r, err_nxt;
  logic [OFF_W-1:0]   stack_r [MAX_DEPTH];

  // effective state after an optional start clear
  logic [OFF_W-1:0]   off_e, leaf_e;
  logic [DEPTH_W-1:0] depth_e;
  phase_t             phase_e;
  logic [7:0]         held_e;
  status_t            status_e;
  err_code_t          err_e;

  logic [OFF_W-1:0]   enc_end;
  logic [OFF_W:0]     data_end;
  logic               comp;
  logic [OFF_W-1:0]   close_off;
  logic [MAX_DEPTH-1:0] hit;
  logic [DEPTH_W-1:0] pops;
  logic               do_unwind;
  logic               do_push;
  logic [OFF_W-1:0]   push_val;
  logic [DEPTH_W-1:0] depth_m1;
  logic [7:0]         b;

  assign b = item.message_byte;

  always_comb begin
    if (item.start_req) begin
      off_e    = '0;
      leaf_e   = '0;
      depth_e  = '0;
      phase_e  = PH_TYPE;
      held_e   = '0;
      status_e = ST_RUN;
      err_e    = ERR_NONE;
    end else begin
      off_e    = off_r;
      leaf_e   = leaf_r;
      depth_e  = depth_r;
      phase_e  = phase_r;
      held_e   = held_r;
      status_e = status_r;
      err_e    = err_r;
    end
  end

  assign depth_m1 = depth_e - DEPTH_W'(1);
  assign enc_end  = (depth_e == '0) ? msg_len_r : stack_r[depth_m1[STK_IW-1:0]];
  assign data_end = {1'b0, off_e} + (OFF_W+1)'(1) + (OFF_W+1)'(b);
  assign comp     = (held_e & comp_mask_r) == comp_match_r;

  // offset at which a record closes on this byte
  assign close_off = (phase_e == PH_LEN) ? data_end[OFF_W-1:0] : off_e + OFF_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      hit[i] = (DEPTH_W'(i) < depth_e) && (stack_r[i] == close_off);
    end
  end
  assign pops = DEPTH_W'($countones(hit));

  always_comb begin
    result     = '0;
    off_nxt    = off_e;
    leaf_nxt   = leaf_e;
    depth_nxt  = depth_e;
    phase_nxt  = phase_e;
    held_nxt   = held_e;
    status_nxt = status_e;
    err_nxt    = err_e;
    do_unwind  = 1'b0;
    do_push    = 1'b0;
    push_val   = data_end[OFF_W-1:0];
    case (status_e)
      ST_ERR: begin
        result.event_kind = EV_ERROR;
        result.error_code = err_e;
      end
      ST_DONE: begin
        result.event_kind = EV_IGNORED;
      end
      default: begin
        case (phase_e)
          PH_TYPE: begin
            if (({1'b0, off_e} + (OFF_W+1)'(HDR_BYTES)) > {1'b0, enc_end}) begin
              status_nxt        = ST_ERR;
              err_nxt           = ERR_TRUNC;
              result.event_kind = EV_ERROR;
              result.error_code = ERR_TRUNC;
            end else begin
              held_nxt          = b;
              phase_nxt         = PH_LEN;
              off_nxt           = off_e + OFF_W'(1);
              result.event_kind = EV_TYPE;
              result.node_type  = b;
              result.node_depth = 4'(depth_e);
            end
          end
          PH_LEN: begin
            if (data_end > {1'b0, enc_end}) begin
              status_nxt        = ST_ERR;
              err_nxt           = ERR_OVERRUN;
              result.event_kind = EV_ERROR;
              result.error_code = ERR_OVERRUN;
            end else if (comp && (b != 8'd0) && (depth_e >= DEPTH_W'(MAX_DEPTH))) begin
              status_nxt        = ST_ERR;
              err_nxt           = ERR_DEEP;
              result.event_kind = EV_ERROR;
              result.error_code = ERR_DEEP;
            end else begin
              result.event_kind   = EV_START;
              result.node_type    = held_e;
              result.node_length  = b;
              result.node_depth   = 4'(depth_e);
              result.is_composite = comp;
              off_nxt             = data_end[OFF_W-1:0];
              if (b == 8'd0) begin
                do_unwind = 1'b1;
              end else if (comp) begin
                do_push   = 1'b1;
                depth_nxt = depth_e + DEPTH_W'(1);
                phase_nxt = PH_TYPE;
              end else begin
                leaf_nxt  = data_end[OFF_W-1:0];
                phase_nxt = PH_DATA;
              end
            end
          end
          default: begin
            result.event_kind = EV_DATA;
            result.node_type  = held_e;
            result.node_depth = 4'(depth_e);
            result.data_out   = b;
            off_nxt           = off_e + OFF_W'(1);
            do_unwind         = (off_e + OFF_W'(1)) == leaf_e;
          end
        endcase
        if (do_unwind) begin
          result.closed_count = 4'(pops + DEPTH_W'(1));
          depth_nxt           = depth_e - pops;
          phase_nxt           = PH_TYPE;
          if (depth_e == pops) begin
            result.root_done = 1'b1;
            status_nxt       = ST_DONE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r    <= '0;
      comp_mask_r  <= 8'd128;
      comp_match_r <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MSG_LEN:    msg_len_r    <= cfg_wdata[OFF_W-1:0];
        CFG_COMP_MASK:  comp_mask_r  <= cfg_wdata[7:0];
        CFG_COMP_MATCH: comp_match_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      leaf_r   <= '0;
      depth_r  <= '0;
      phase_r  <= PH_TYPE;
      held_r   <= '0;
      status_r <= ST_RUN;
      err_r    <= ERR_NONE;
    end else if (take) begin
      off_r    <= off_nxt;
      leaf_r   <= leaf_nxt;
      depth_r  <= depth_nxt;
      phase_r  <= phase_nxt;
      held_r   <= held_nxt;
      status_r <= status_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && do_push) begin
      stack_r[depth_e[STK_IW-1:0]] <= push_val;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("open depth beyond stack size");

  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == ST_DONE) |-> (depth_r == '0))
    else $error("root done with composites still open");

  a_data_running: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (status_r == ST_RUN && leaf_r != '0))
    else $error("leaf data phase outside a running parse");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == ST_ERR && take && !item.start_req) |=> (status_r == ST_ERR))
    else $error("error status cleared without start");

endmodule

// ----- src/nstp_outbuf.sv -----
// two-entry skid buffer on the result channel
module nstp_outbuf
  import nstp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  out_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  out_t       slot_r [2];
  logic       pop;
  logic       wr_hi;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign full      = cnt_r == 2'd2;
  assign out_valid = cnt_r != 2'd0;
  assign out_data  = slot_r[0];
  assign cnt_nxt   = cnt_r - {1'b0, pop} + {1'b0, push};
  assign wr_hi     = (cnt_r - {1'b0, pop}) != 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) begin
      slot_r[0] <= slot_r[1];
    end
    if (push) begin
      if (wr_hi) begin
        slot_r[1] <= push_data;
      end else begin
        slot_r[0] <= push_data;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full result buffer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_hold_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

// ----- src/nested_tlv_stream_parser.sv -----
// top level of the nested tlv stream parser
//
//   channel | ports                          | direction
//   in      | in_valid in_stall in_data      | byte transactions in
//   out     | out_valid out_stall out_data   | one event per byte out
//   cfg     | cfg_we cfg_index cfg_wdata     | register writes
//
// one byte per cycle while in_stall is low: offset compares, stack compare and push or pop in one stage
// each accepted byte's event is written to a two-entry result buffer and is visible there in the next cycle
// in_stall is high only when both result slots are occupied
// synchronous active-low reset; registers return to defaults, stack is not cleared
module nested_tlv_stream_parser
  import nstp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic take;
  logic full;
  out_t result;

  assign take     = in_valid && !full;
  assign in_stall = full;

  nstp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .item      (in_data),
    .result    (result)
  );

  nstp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
